[rtl/lmts_pkg.sv]
// lmts_pkg: types and constants for the lcd mode timing sequencer
// no dependencies; used by lmts_step and lcd_mode_timing_sequencer
`timescale 1ns / 1ps
`default_nettype none

package lmts_pkg;

  localparam int unsigned ACC_W  = 10;
  localparam int unsigned LINE_W = 8;

  localparam logic [ACC_W-1:0] OAM_CYCLES    = 10'd80;
  localparam logic [ACC_W-1:0] XFER_CYCLES   = 10'd172;
  localparam logic [ACC_W-1:0] HBLANK_CYCLES = 10'd204;
  localparam logic [ACC_W-1:0] LINE_CYCLES   = 10'd456;
  localparam logic [LINE_W-1:0] LAST_VIS_LINE = 8'd143;
  localparam logic [LINE_W-1:0] LAST_LINE     = 8'd153;

  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  localparam logic [1:0] REG_HBLANK_IRQ_EN = 2'd0;
  localparam logic [1:0] REG_VBLANK_IRQ_EN = 2'd1;
  localparam logic [1:0] REG_OAM_IRQ_EN    = 2'd2;

  typedef enum logic [3:0] {
    ST_HBLANK = 4'b0001,
    ST_VBLANK = 4'b0010,
    ST_OAM    = 4'b0100,
    ST_XFER   = 4'b1000
  } mode_state_t;

  typedef struct packed {
    mode_state_t       mode;
    logic [ACC_W-1:0]  accum;
    logic [LINE_W-1:0] line;
  } seq_state_t;

  typedef struct packed {
    logic hblank_en;
    logic vblank_en;
    logic oam_en;
  } irq_cfg_t;

  typedef struct packed {
    logic [1:0]        lcd_mode;
    logic [LINE_W-1:0] current_line;
    logic              vblank_irq;
    logic              stat_irq;
    logic              draw_line_strobe;
    logic              frame_done;
  } seq_result_t;

  function automatic logic [1:0] mode_code(input mode_state_t st);
    logic [1:0] code;
    unique case (st)
      ST_HBLANK: code = MODE_HBLANK;
      ST_VBLANK: code = MODE_VBLANK;
      ST_OAM:    code = MODE_OAM;
      ST_XFER:   code = MODE_XFER;
      default:   code = MODE_OAM;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[rtl/lmts_step.sv]
// lmts_step: one item of mode timing, accumulate and make at most one transition
// depends on lmts_pkg
`timescale 1ns / 1ps
`default_nettype none

module lmts_step
  import lmts_pkg::*;
(
  input  seq_state_t  cur,
  input  irq_cfg_t    cfg,
  input  logic [7:0]  elapsed,
  output seq_state_t  nxt,
  output seq_result_t res
);

  logic [ACC_W-1:0]  sum;
  logic [LINE_W-1:0] line_inc;
  logic              vblank_irq;
  logic              stat_irq;
  logic              draw;
  logic              frame;

  assign sum      = cur.accum + {{(ACC_W-8){1'b0}}, elapsed};
  assign line_inc = cur.line + 8'd1;

  always_comb begin
    nxt.mode   = cur.mode;
    nxt.accum  = sum;
    nxt.line   = cur.line;
    vblank_irq = 1'b0;
    stat_irq   = 1'b0;
    draw       = 1'b0;
    frame      = 1'b0;
    unique case (cur.mode)
      ST_HBLANK: begin
        if (sum >= HBLANK_CYCLES) begin
          nxt.accum = '0;
          if (cur.line >= LAST_VIS_LINE) begin
            nxt.mode   = ST_VBLANK;
            stat_irq   = cfg.vblank_en;
            vblank_irq = 1'b1;
            frame      = 1'b1;
          end else begin
            nxt.line = line_inc;
            nxt.mode = ST_OAM;
            stat_irq = cfg.oam_en;
          end
        end
      end
      ST_OAM: begin
        if (sum >= OAM_CYCLES) begin
          nxt.accum = '0;
          nxt.mode  = ST_XFER;
        end
      end
      ST_XFER: begin
        if (sum >= XFER_CYCLES) begin
          nxt.accum = '0;
          nxt.mode  = ST_HBLANK;
          draw      = 1'b1;
          stat_irq  = cfg.hblank_en;
        end
      end
      ST_VBLANK: begin
        if (sum >= LINE_CYCLES) begin
          nxt.accum = '0;
          if (line_inc > LAST_LINE) begin
            nxt.line = '0;
            nxt.mode = ST_OAM;
            stat_irq = cfg.oam_en;
          end else begin
            nxt.line = line_inc;
          end
        end
      end
      default: begin
        nxt.mode = ST_OAM;
      end
    endcase
  end

  assign res.lcd_mode         = mode_code(nxt.mode);
  assign res.current_line     = nxt.line;
  assign res.vblank_irq       = vblank_irq;
  assign res.stat_irq         = stat_irq;
  assign res.draw_line_strobe = draw;
  assign res.frame_done       = frame;

endmodule

`default_nettype wire

[rtl/lcd_mode_timing_sequencer.sv]
// lcd_mode_timing_sequencer: top level, input register, sequencer state, result register
// depends on lmts_pkg and lmts_step
//
//   channel | direction | handshake         | payload
//   in      | input     | in_valid/in_stall  | in_elapsed_cycles
//   out     | output    | out_valid/out_stall| out_lcd_mode, out_current_line, pulses
//   cfg     | input     | cfg_we             | cfg_idx, cfg_wdata
//
// one item per cycle unless the output is stalled; an accepted item goes through the input register,
// then one compare-and-increment pass into the result register
// reset: synchronous, active low; mode oam scan, line 0, accumulator 0, enables 0
// a stalled result holds in the output register while the input register takes one more item
`timescale 1ns / 1ps
`default_nettype none

module lcd_mode_timing_sequencer
  import lmts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_elapsed_cycles,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_lcd_mode,
  output logic [7:0] out_current_line,
  output logic       out_vblank_irq,
  output logic       out_stat_irq,
  output logic       out_draw_line_strobe,
  output logic       out_frame_done,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic       cfg_wdata
);

  irq_cfg_t    cfg_r;
  seq_state_t  state_r;
  seq_state_t  state_nxt;
  seq_result_t res_nxt;
  seq_result_t res_r;
  logic        s1_valid_r;
  logic [7:0]  s1_elapsed_r;
  logic        out_valid_r;
  logic        advance;
  logic        s1_load;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign s1_load  = in_valid && !in_stall;

  lmts_step u_step (
    .cur     (state_r),
    .cfg     (cfg_r),
    .elapsed (s1_elapsed_r),
    .nxt     (state_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_HBLANK_IRQ_EN: cfg_r.hblank_en <= cfg_wdata;
        REG_VBLANK_IRQ_EN: cfg_r.vblank_en <= cfg_wdata;
        REG_OAM_IRQ_EN:    cfg_r.oam_en    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode  <= ST_OAM;
      state_r.accum <= '0;
      state_r.line  <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (advance) begin
        state_r <= state_nxt;
      end
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_elapsed_r <= in_elapsed_cycles;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_lcd_mode         = res_r.lcd_mode;
  assign out_current_line     = res_r.current_line;
  assign out_vblank_irq       = res_r.vblank_irq;
  assign out_stat_irq         = res_r.stat_irq;
  assign out_draw_line_strobe = res_r.draw_line_strobe;
  assign out_frame_done       = res_r.frame_done;

endmodule

`default_nettype wire

[rtl/lmts_checker.sv]
// lmts_checker: port-level assertions for lcd_mode_timing_sequencer, bound to the top level
// depends on lmts_pkg
`timescale 1ns / 1ps
`default_nettype none

module lmts_checker
  import lmts_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] in_elapsed_cycles,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_lcd_mode,
  input wire logic [7:0] out_current_line,
  input wire logic       out_vblank_irq,
  input wire logic       out_draw_line_strobe,
  input wire logic       out_frame_done
);

  // stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_elapsed_cycles))
    else $error("stalled input item changed");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_lcd_mode)
      && $stable(out_current_line))
    else $error("stalled result changed");

  // end of frame goes with vblank entry
  a_frame_vblank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_vblank_irq && out_lcd_mode == MODE_VBLANK)
    else $error("frame done without vblank entry");

  // draw strobe only on entering hblank
  a_draw_hblank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_draw_line_strobe |-> out_lcd_mode == MODE_HBLANK
      && !out_frame_done)
    else $error("draw strobe outside hblank entry");

  // line stays in range, visible modes stay below vblank lines
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_current_line <= LAST_LINE
      && (out_lcd_mode == MODE_VBLANK || out_current_line <= LAST_VIS_LINE))
    else $error("line out of range for mode");

endmodule

bind lcd_mode_timing_sequencer lmts_checker u_lmts_checker (.*);

`default_nettype wire

[dv/testbench.sv]
// testbench for lcd_mode_timing_sequencer: random and directed elapsed-cycle items,
// in-line mode/line predictor, per-field result checks, random idling and a long output hold
// depends on lmts_pkg and the lcd_mode_timing_sequencer rtl
`timescale 1ns / 1ps

module testbench;
  import lmts_pkg::*;

  localparam int STUCK_LIMIT = 4000;
  localparam int LONG_HOLD   = 60;
  localparam int RAND_ITEMS  = 175;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_elapsed_cycles = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_lcd_mode;
  logic [7:0] out_current_line;
  logic       out_vblank_irq;
  logic       out_stat_irq;
  logic       out_draw_line_strobe;
  logic       out_frame_done;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_idx = REG_HBLANK_IRQ_EN;
  logic       cfg_wdata = 1'b0;

  lcd_mode_timing_sequencer dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_elapsed_cycles    (in_elapsed_cycles),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_lcd_mode         (out_lcd_mode),
    .out_current_line     (out_current_line),
    .out_vblank_irq       (out_vblank_irq),
    .out_stat_irq         (out_stat_irq),
    .out_draw_line_strobe (out_draw_line_strobe),
    .out_frame_done       (out_frame_done),
    .cfg_we               (cfg_we),
    .cfg_idx              (cfg_idx),
    .cfg_wdata            (cfg_wdata)
  );

  // predictor state
  logic [1:0]        pm_mode = MODE_OAM;
  logic [ACC_W-1:0]  pm_accum = '0;
  logic [LINE_W-1:0] pm_line = '0;
  irq_cfg_t          pm_en = '0;

  logic [7:0]  elapsed_pending[$];
  seq_result_t timing_due_q[$];

  logic in_took = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_left = 0;
  int   holds_asked = 0;
  int   holds_begun = 0;
  int   stuck_cycles = 0;
  int   error_count = 0;
  int   items_taken = 0;
  int   results_seen = 0;
  int   frames_seen = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic seq_result_t advance_lcd_timing(input logic [7:0] cyc);
    seq_result_t r;
    r = '0;
    pm_accum = pm_accum + {2'b00, cyc};
    case (pm_mode)
      MODE_HBLANK: begin
        if (pm_accum >= HBLANK_CYCLES) begin
          pm_accum = '0;
          if (pm_line >= LAST_VIS_LINE) begin
            pm_mode      = MODE_VBLANK;
            r.stat_irq   = pm_en.vblank_en;
            r.vblank_irq = 1'b1;
            r.frame_done = 1'b1;
          end else begin
            pm_line    = pm_line + 1'b1;
            pm_mode    = MODE_OAM;
            r.stat_irq = pm_en.oam_en;
          end
        end
      end
      MODE_OAM: begin
        if (pm_accum >= OAM_CYCLES) begin
          pm_accum = '0;
          pm_mode  = MODE_XFER;
        end
      end
      MODE_XFER: begin
        if (pm_accum >= XFER_CYCLES) begin
          pm_accum           = '0;
          pm_mode            = MODE_HBLANK;
          r.draw_line_strobe = 1'b1;
          r.stat_irq         = pm_en.hblank_en;
        end
      end
      default: begin
        if (pm_accum >= LINE_CYCLES) begin
          pm_accum = '0;
          pm_line  = pm_line + 1'b1;
          if (pm_line > LAST_LINE) begin
            pm_line    = '0;
            pm_mode    = MODE_OAM;
            r.stat_irq = pm_en.oam_en;
          end
        end
      end
    endcase
    r.lcd_mode     = pm_mode;
    r.current_line = pm_line;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (elapsed_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid          <= 1'b1;
        in_elapsed_cycles <= elapsed_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_begun != holds_asked) begin
      out_stall   <= 1'b1;
      hold_left   <= LONG_HOLD;
      holds_begun <= holds_begun + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor and predictor
  always @(posedge clk) begin : monitor
    seq_result_t got;
    seq_result_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        got.lcd_mode         = out_lcd_mode;
        got.current_line     = out_current_line;
        got.vblank_irq       = out_vblank_irq;
        got.stat_irq         = out_stat_irq;
        got.draw_line_strobe = out_draw_line_strobe;
        got.frame_done       = out_frame_done;
        results_seen++;
        if (got.frame_done === 1'b1) frames_seen++;
        if (timing_due_q.size() == 0) begin
          flag_mismatch("result with no item pending");
        end else begin
          want = timing_due_q.pop_front();
          if (got.lcd_mode !== want.lcd_mode)
            flag_mismatch($sformatf("lcd_mode %0d, want %0d", got.lcd_mode, want.lcd_mode));
          if (got.current_line !== want.current_line)
            flag_mismatch($sformatf("current_line %0d, want %0d",
                                    got.current_line, want.current_line));
          if (got.vblank_irq !== want.vblank_irq)
            flag_mismatch($sformatf("vblank_irq %b, want %b", got.vblank_irq, want.vblank_irq));
          if (got.stat_irq !== want.stat_irq)
            flag_mismatch($sformatf("stat_irq %b, want %b", got.stat_irq, want.stat_irq));
          if (got.draw_line_strobe !== want.draw_line_strobe)
            flag_mismatch($sformatf("draw_line_strobe %b, want %b",
                                    got.draw_line_strobe, want.draw_line_strobe));
          if (got.frame_done !== want.frame_done)
            flag_mismatch($sformatf("frame_done %b, want %b", got.frame_done, want.frame_done));
        end
      end
      if (in_valid && !in_stall) begin
        timing_due_q.push_back(advance_lcd_timing(in_elapsed_cycles));
        items_taken++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
    end
  end

  // watchdog
  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("timeout: no item moved for %0d cycles", STUCK_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic write_irq_reg(input logic [1:0] idx, input logic val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_HBLANK_IRQ_EN: pm_en.hblank_en = val;
      REG_VBLANK_IRQ_EN: pm_en.vblank_en = val;
      REG_OAM_IRQ_EN:    pm_en.oam_en    = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_irq_enables(input logic h, input logic v, input logic o);
    write_irq_reg(REG_HBLANK_IRQ_EN, h);
    write_irq_reg(REG_VBLANK_IRQ_EN, v);
    write_irq_reg(REG_OAM_IRQ_EN, o);
  endtask

  task automatic wait_drained();
    while (elapsed_pending.size() != 0 || in_valid || timing_due_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly long steps so that the frame reaches vblank, some fully random
  task automatic run_phase(input int s_pct, input int r_pct, input logic h, input logic v,
                           input logic o, input bit long_hold);
    wait_drained();
    set_irq_enables(h, v, o);
    @(posedge clk);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    if (long_hold) holds_asked++;
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if ($urandom_range(99) < 85)
        elapsed_pending.push_back(8'($urandom_range(255, 204)));
      else
        elapsed_pending.push_back(8'($urandom_range(255, 0)));
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    set_irq_enables(1'b1, 1'b1, 1'b1);
    @(posedge clk);
    send_idle_pct = 8;
    recv_idle_pct = 78;
    // exact thresholds, one below them, excess cycles and empty steps
    elapsed_pending = '{8'd0, 8'd255, 8'd171, 8'd1, 8'd203, 8'd1, 8'd79, 8'd1, 8'd255,
                        8'd0, 8'd255, 8'd40, 8'd40, 8'd128, 8'd43, 8'd1, 8'd255};
    run_phase(8, 78, 1'b1, 1'b1, 1'b1, 1'b0);
    run_phase(78, 8, 1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(0, 0, 1'b0, 1'b1, 1'b1, 1'b0);
    run_phase(0, 0, 1'b1, 1'b0, 1'b0, 1'b1);
    wait_drained();
    repeat (8) @(negedge clk);
    if (timing_due_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", timing_due_q.size()));
    $display("ran %0d items and %0d results over four idling phases, %0d frame ends,",
             items_taken, results_seen, frames_seen);
    $display("irq enables all on, all off and mixed, %0d long output holds", holds_begun);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
